/* rtl/aes_cts_pkg.sv */
// Package with the constants, tables and round functions of the AES-256 CBC stream engine.
`default_nettype none

package aes_cts_pkg;

   localparam int BLOCK_W = 128;
   localparam int COUNT_W = 5;
   localparam int CSR_ADDR_W = 6;
   localparam int CSR_IDX_W = 3;
   localparam int RK_BANK_DEPTH = 15;
   localparam int RK_IDX_W = 4;

   localparam logic [COUNT_W-1:0] BLOCK_BYTES = 5'd16;
   localparam logic [4:0] KX_LAST = 5'd29;
   localparam logic [3:0] STEP_LAST = 4'd15;
   localparam logic [RK_IDX_W-1:0] LAST_ROUND = 4'd14;

   localparam logic [CSR_IDX_W-1:0] REG_KEY0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_KEY1 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_KEY2 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_KEY3 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_IV_UPPER = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_IV_LOWER = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_DIRECTION = 3'd6;

   typedef logic [7:0] byte_table_type [256];

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] p;
      logic [7:0] x;
      logic [7:0] y;
      p = '0;
      x = a;
      y = b;
      for (int i = 0; i < 8; i++) begin
         if (y[0]) p = p ^ x;
         x = xtime(x);
         y = y >> 1;
      end
      return p;
   endfunction

   function automatic logic [7:0] ginv(input logic [7:0] x);
      logic [7:0] r;
      logic [7:0] p;
      r = 8'h01;
      p = x;
      for (int i = 1; i < 8; i++) begin
         p = gmul(p, p);
         r = gmul(r, p);
      end
      return r;
   endfunction

   function automatic logic [7:0] sbox_calc(input logic [7:0] x);
      logic [7:0] b;
      b = ginv(x);
      return b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]} ^ {b[3:0], b[7:4]}
         ^ 8'h63;
   endfunction

   function automatic byte_table_type make_sbox();
      byte_table_type t;
      for (int i = 0; i < 256; i++) t[i] = sbox_calc(8'(i));
      return t;
   endfunction

   function automatic byte_table_type make_inv_sbox();
      byte_table_type t;
      for (int i = 0; i < 256; i++) t[sbox_calc(8'(i))] = 8'(i);
      return t;
   endfunction

   localparam byte_table_type SBOX = make_sbox();
   localparam byte_table_type INV_SBOX = make_inv_sbox();

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
   endfunction

   function automatic logic [31:0] rot_word(input logic [31:0] w);
      return {w[23:0], w[31:24]};
   endfunction

   function automatic logic [BLOCK_W-1:0] lead_mask(input logic [COUNT_W-1:0] c);
      return ~({BLOCK_W{1'b1}} >> {c, 3'b000});
   endfunction

   function automatic logic [BLOCK_W-1:0] shl_bytes(input logic [BLOCK_W-1:0] v,
                                                    input logic [COUNT_W-1:0] n);
      return v << {n, 3'b000};
   endfunction

   function automatic logic [BLOCK_W-1:0] shr_bytes(input logic [BLOCK_W-1:0] v,
                                                    input logic [COUNT_W-1:0] n);
      return v >> {n, 3'b000};
   endfunction

   function automatic logic [BLOCK_W-1:0] fwd_round(input logic [BLOCK_W-1:0] s,
                                                    input logic [BLOCK_W-1:0] rk,
                                                    input logic last_rnd);
      logic [7:0] b [16];
      logic [7:0] t [16];
      logic [BLOCK_W-1:0] o;
      logic [7:0] a0;
      logic [7:0] a1;
      logic [7:0] a2;
      logic [7:0] a3;
      for (int i = 0; i < 16; i++) b[i] = SBOX[s[127-8*i -: 8]];
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++) t[r+4*c] = b[r+4*((c+r)&3)];
      if (!last_rnd) begin
         for (int c = 0; c < 4; c++) begin
            a0 = t[4*c];
            a1 = t[4*c+1];
            a2 = t[4*c+2];
            a3 = t[4*c+3];
            t[4*c] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
            t[4*c+1] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
            t[4*c+2] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
            t[4*c+3] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
         end
      end
      for (int i = 0; i < 16; i++) o[127-8*i -: 8] = t[i] ^ rk[127-8*i -: 8];
      return o;
   endfunction

   function automatic logic [BLOCK_W-1:0] inv_round(input logic [BLOCK_W-1:0] s,
                                                    input logic [BLOCK_W-1:0] rk,
                                                    input logic last_rnd);
      logic [7:0] t [16];
      logic [BLOCK_W-1:0] o;
      logic [7:0] a0;
      logic [7:0] a1;
      logic [7:0] a2;
      logic [7:0] a3;
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++) t[r+4*((c+r)&3)] = s[127-8*(r+4*c) -: 8];
      for (int i = 0; i < 16; i++) t[i] = INV_SBOX[t[i]] ^ rk[127-8*i -: 8];
      if (!last_rnd) begin
         for (int c = 0; c < 4; c++) begin
            a0 = t[4*c];
            a1 = t[4*c+1];
            a2 = t[4*c+2];
            a3 = t[4*c+3];
            t[4*c] = gmul(a0, 8'd14) ^ gmul(a1, 8'd11) ^ gmul(a2, 8'd13) ^ gmul(a3, 8'd9);
            t[4*c+1] = gmul(a0, 8'd9) ^ gmul(a1, 8'd14) ^ gmul(a2, 8'd11) ^ gmul(a3, 8'd13);
            t[4*c+2] = gmul(a0, 8'd13) ^ gmul(a1, 8'd9) ^ gmul(a2, 8'd14) ^ gmul(a3, 8'd11);
            t[4*c+3] = gmul(a0, 8'd11) ^ gmul(a1, 8'd13) ^ gmul(a2, 8'd9) ^ gmul(a3, 8'd14);
         end
      end
      for (int i = 0; i < 16; i++) o[127-8*i -: 8] = t[i];
      return o;
   endfunction

endpackage

`default_nettype wire

/* rtl/aes_cts_ifs.sv */
// Request and response stream interfaces of the AES-256 CBC stream engine.
`default_nettype none

interface aes_cts_req_if import aes_cts_pkg::*; ();
   logic valid;
   logic ready;
   logic [63:0] in_hi;
   logic [63:0] in_lo;
   logic [COUNT_W-1:0] in_count;
   logic in_last;

   modport source (output valid, output in_hi, output in_lo, output in_count,
                   output in_last, input ready);
   modport sink (input valid, input in_hi, input in_lo, input in_count,
                 input in_last, output ready);
endinterface

interface aes_cts_rsp_if import aes_cts_pkg::*; ();
   logic valid;
   logic ready;
   logic [63:0] out_hi;
   logic [63:0] out_lo;
   logic [COUNT_W-1:0] out_count;
   logic out_last;
   logic out_error;

   modport source (output valid, output out_hi, output out_lo, output out_count,
                   output out_last, output out_error, input ready);
   modport sink (input valid, input out_hi, input out_lo, input out_count,
                 input out_last, input out_error, output ready);
endinterface

`default_nettype wire

/* rtl/aes_cts_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module aes_cts_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/aes_cbc_cts_stream_engine.sv */
// AES-256 CBC stream engine with ciphertext stealing, one round per cycle.
// A request takes at most two cipher passes, each run on the shared round unit
// fed from the two round key RAM banks. No request is taken until all
// responses of the previous one are delivered. A key write starts a key
// expansion into the RAMs during which no request is accepted.
// Synchronous reset clears the configuration, chaining value and held block.
`default_nettype none

module aes_cbc_cts_stream_engine import aes_cts_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   aes_cts_req_if.sink           req_stream,
   aes_cts_rsp_if.source         rsp_stream,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [63:0]           pwdata,
   output logic [63:0]           prdata,
   output logic                  pready
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_KEYX = 3'd1;
   localparam logic [2:0] ST_AES1 = 3'd2;
   localparam logic [2:0] ST_AES2 = 3'd3;
   localparam logic [2:0] ST_FIN  = 3'd4;
   localparam logic [2:0] ST_EMIT = 3'd5;

   localparam logic [1:0] PH_IDLE   = 2'd0;
   localparam logic [1:0] PH_FIRST  = 2'd1;
   localparam logic [1:0] PH_STREAM = 2'd2;

   localparam logic [2:0] K_E_OPEN   = 3'd0;
   localparam logic [2:0] K_E_STREAM = 3'd1;
   localparam logic [2:0] K_D_PH1    = 3'd2;
   localparam logic [2:0] K_D_PH0    = 3'd3;
   localparam logic [2:0] K_D_STREAM = 3'd4;

   typedef struct packed {
      logic [BLOCK_W-1:0] data;
      logic [COUNT_W-1:0] count;
      logic               last;
      logic               err;
   } result_type;

   function automatic logic needs_cipher(input logic [2:0] kind, input logic last);
      return ((kind == K_E_OPEN || kind == K_D_PH1) && last) || kind == K_E_STREAM
         || kind == K_D_STREAM;
   endfunction

   logic [63:0] key_ff [4];
   logic [63:0] key_in [4];
   logic [63:0] iv_hi_ff, iv_hi_in, iv_lo_ff, iv_lo_in;
   logic dir_ff, dir_in;
   logic csr_wr, key_wr;
   logic [CSR_IDX_W-1:0] csr_idx;

   logic [2:0] state_ff, state_in;
   logic [3:0] st_ff, st_in;
   logic [4:0] kx_cnt_ff, kx_cnt_in;
   logic emit_ff, emit_in, two_ff, two_in;
   logic [1:0] phase_ff, phase_in;
   logic [BLOCK_W-1:0] chain_ff, chain_in, held_ff, held_in;

   logic [31:0] win_ff [8];
   logic [31:0] win_in [8];
   logic [7:0] rcon_ff, rcon_in;
   logic [31:0] kx_t, kx_wa, kx_wb;
   logic [63:0] kx_data;
   logic kx_step;

   logic [RK_IDX_W-1:0] rnd_idx, rd_idx;
   logic [63:0] rk_even, rk_odd;
   logic [BLOCK_W-1:0] round_key, round_out;
   logic [BLOCK_W-1:0] aes_state_ff, aes_state_in, aes_src_ff, aes_src_in;
   logic [BLOCK_W-1:0] r1_ff, r1_in;

   logic req_fire, rsp_fire;
   logic [COUNT_W-1:0] c_sat, c_ff, c_in, cx;
   logic [BLOCK_W-1:0] x_new, x_ff, x_in, iv, m, r1, r2, src1;
   logic [2:0] kind_new, kind_ff, kind_in;
   logic last_ff, last_in, need2;

   result_type res_ff [2];
   result_type res_in [2];
   result_type res0, res1;
   logic [1:0] res_num;
   logic [BLOCK_W-1:0] fin_chain, fin_held;
   logic [1:0] fin_phase;

   // Configuration port.
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;
   assign csr_idx = paddr[CSR_ADDR_W-1:3];
   assign key_wr = csr_wr && (csr_idx inside {[REG_KEY0:REG_KEY3]});

   always_comb begin
      key_in = key_ff;
      iv_hi_in = iv_hi_ff;
      iv_lo_in = iv_lo_ff;
      dir_in = dir_ff;
      if (key_wr) key_in[csr_idx[1:0]] = pwdata;
      if (csr_wr && csr_idx == REG_IV_UPPER) iv_hi_in = pwdata;
      if (csr_wr && csr_idx == REG_IV_LOWER) iv_lo_in = pwdata;
      if (csr_wr && csr_idx == REG_DIRECTION) dir_in = pwdata[0];
   end

   always_comb begin
      case (csr_idx)
         REG_KEY0: prdata = key_ff[0];
         REG_KEY1: prdata = key_ff[1];
         REG_KEY2: prdata = key_ff[2];
         REG_KEY3: prdata = key_ff[3];
         REG_IV_UPPER: prdata = iv_hi_ff;
         REG_IV_LOWER: prdata = iv_lo_ff;
         REG_DIRECTION: prdata = {63'd0, dir_ff};
         default: prdata = '0;
      endcase
   end

   // Key expansion, two words per cycle into the even and odd round key banks.
   assign kx_step = (state_ff == ST_KEYX) && (kx_cnt_ff >= 5'd4);

   always_comb begin
      case (kx_cnt_ff[1:0])
         2'd0: kx_t = sub_word(rot_word(win_ff[7])) ^ {rcon_ff, 24'h0};
         2'd2: kx_t = sub_word(win_ff[7]);
         default: kx_t = win_ff[7];
      endcase
      kx_wa = win_ff[0] ^ kx_t;
      kx_wb = win_ff[1] ^ kx_wa;
      kx_data = (kx_cnt_ff < 5'd4) ? key_ff[kx_cnt_ff[1:0]] : {kx_wa, kx_wb};
      win_in = win_ff;
      rcon_in = rcon_ff;
      if (key_wr) begin
         for (int i = 0; i < 4; i++) begin
            win_in[2*i] = key_in[i][63:32];
            win_in[2*i+1] = key_in[i][31:0];
         end
         rcon_in = 8'h01;
      end else if (kx_step) begin
         for (int i = 0; i < 6; i++) win_in[i] = win_ff[i+2];
         win_in[6] = kx_wa;
         win_in[7] = kx_wb;
         if (kx_cnt_ff[1:0] == 2'd0) rcon_in = xtime(rcon_ff);
      end
   end

   // Round key banks: entry r of the even bank holds round r bytes 0..7, of the odd bank bytes 8..15.
   assign rnd_idx = (st_ff > STEP_LAST - 4'd1) ? LAST_ROUND : st_ff;
   assign rd_idx = dir_ff ? LAST_ROUND - rnd_idx : rnd_idx;

   aes_cts_ram #(.WIDTH(64), .DEPTH(RK_BANK_DEPTH)) u_rk_even (
      .clock   (clock),
      .wr_en   (state_ff == ST_KEYX && !kx_cnt_ff[0]),
      .wr_addr (kx_cnt_ff[4:1]),
      .wr_data (kx_data),
      .rd_addr (rd_idx),
      .rd_data (rk_even)
   );

   aes_cts_ram #(.WIDTH(64), .DEPTH(RK_BANK_DEPTH)) u_rk_odd (
      .clock   (clock),
      .wr_en   (state_ff == ST_KEYX && kx_cnt_ff[0]),
      .wr_addr (kx_cnt_ff[4:1]),
      .wr_data (kx_data),
      .rd_addr (rd_idx),
      .rd_data (rk_odd)
   );

   assign round_key = {rk_even, rk_odd};
   assign round_out = dir_ff ? inv_round(aes_state_ff, round_key, st_ff == STEP_LAST)
                             : fwd_round(aes_state_ff, round_key, st_ff == STEP_LAST);

   // Request capture.
   assign req_fire = req_stream.valid && req_stream.ready;
   assign rsp_fire = rsp_stream.valid && rsp_stream.ready;
   assign req_stream.ready = (state_ff == ST_IDLE);
   assign iv = {iv_hi_ff, iv_lo_ff};

   always_comb begin
      if (!req_stream.in_last) c_sat = BLOCK_BYTES;
      else if (req_stream.in_count > BLOCK_BYTES) c_sat = BLOCK_BYTES;
      else c_sat = req_stream.in_count;
      x_new = {req_stream.in_hi, req_stream.in_lo} & lead_mask(c_sat);
      if (!dir_ff) kind_new = (phase_ff == PH_STREAM) ? K_E_STREAM : K_E_OPEN;
      else if (phase_ff == PH_FIRST) kind_new = K_D_PH1;
      else if (phase_ff == PH_STREAM) kind_new = K_D_STREAM;
      else kind_new = K_D_PH0;
      case (kind_new)
         K_E_OPEN: src1 = shl_bytes(iv, c_sat) | shr_bytes(x_new ^ iv, BLOCK_BYTES - c_sat);
         K_E_STREAM: src1 = held_ff ^ chain_ff;
         K_D_PH1: src1 = shl_bytes(held_ff, c_sat) | shr_bytes(x_new, BLOCK_BYTES - c_sat);
         K_D_STREAM: src1 = held_ff;
         default: src1 = '0;
      endcase
   end

   assign need2 = (kind_ff == K_E_STREAM || kind_ff == K_D_STREAM) && last_ff
      && (c_ff != '0);
   assign m = lead_mask(c_ff);
   assign cx = BLOCK_BYTES - c_ff;
   assign r1 = need2 ? r1_ff : aes_state_ff;
   assign r2 = aes_state_ff;

   // Result assembly once the cipher passes are done.
   always_comb begin
      res0 = '{data: '0, count: BLOCK_BYTES, last: 1'b0, err: 1'b0};
      res1 = '{data: '0, count: c_ff, last: 1'b1, err: 1'b0};
      res_num = 2'd0;
      fin_chain = '0;
      fin_held = '0;
      fin_phase = PH_IDLE;
      case (kind_ff)
         K_E_OPEN: begin
            if (!last_ff) begin
               res0.data = iv;
               res_num = 2'd1;
               fin_chain = iv;
               fin_held = x_ff;
               fin_phase = PH_STREAM;
            end else begin
               res0.data = (iv & m) | shr_bytes(r1, c_ff);
               res0.last = (c_ff == '0);
               res1.data = shl_bytes(r1, cx);
               res_num = (c_ff == '0) ? 2'd1 : 2'd2;
            end
         end
         K_E_STREAM: begin
            if (!last_ff) begin
               res0.data = r1;
               res_num = 2'd1;
               fin_chain = r1;
               fin_held = x_ff;
               fin_phase = PH_STREAM;
            end else if (c_ff == '0) begin
               res0.data = r1;
               res0.last = 1'b1;
               res_num = 2'd1;
            end else begin
               res0.data = (c_ff == BLOCK_BYTES) ? r1 : r2;
               res1.data = (c_ff == BLOCK_BYTES) ? r2 : (r1 & m);
               res_num = 2'd2;
            end
         end
         K_D_PH1: begin
            if (!last_ff) begin
               fin_chain = held_ff;
               fin_held = x_ff;
               fin_phase = PH_STREAM;
            end else begin
               res0.data = (held_ff ^ shl_bytes(r1, cx)) & m;
               res0.count = c_ff;
               res0.last = 1'b1;
               res_num = 2'd1;
            end
         end
         K_D_PH0: begin
            if (!last_ff) begin
               fin_chain = chain_ff;
               fin_held = x_ff;
               fin_phase = PH_FIRST;
            end else begin
               res0.count = '0;
               res0.last = 1'b1;
               res0.err = (c_ff != BLOCK_BYTES);
               res_num = 2'd1;
            end
         end
         K_D_STREAM: begin
            if (!last_ff) begin
               res0.data = r1 ^ chain_ff;
               res_num = 2'd1;
               fin_chain = held_ff;
               fin_held = x_ff;
               fin_phase = PH_STREAM;
            end else if (c_ff == '0) begin
               res0.data = r1 ^ chain_ff;
               res0.last = 1'b1;
               res_num = 2'd1;
            end else begin
               res0.data = ((c_ff == BLOCK_BYTES) ? r1 : r2) ^ chain_ff;
               res1.data = (c_ff == BLOCK_BYTES) ? (r2 ^ held_ff) : ((r1 ^ x_ff) & m);
               res_num = 2'd2;
            end
         end
         default: res_num = 2'd0;
      endcase
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      st_in = st_ff;
      kx_cnt_in = kx_cnt_ff;
      emit_in = emit_ff;
      two_in = two_ff;
      chain_in = chain_ff;
      held_in = held_ff;
      phase_in = phase_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = needs_cipher(kind_new, req_stream.in_last) ? ST_AES1 : ST_FIN;
               st_in = '0;
            end
         end
         ST_KEYX: begin
            if (kx_cnt_ff == KX_LAST) state_in = ST_IDLE;
            else kx_cnt_in = kx_cnt_ff + 5'd1;
         end
         ST_AES1: begin
            st_in = st_ff + 4'd1;
            if (st_ff == STEP_LAST) state_in = need2 ? ST_AES2 : ST_FIN;
         end
         ST_AES2: begin
            st_in = st_ff + 4'd1;
            if (st_ff == STEP_LAST) state_in = ST_FIN;
         end
         ST_FIN: begin
            chain_in = fin_chain;
            held_in = fin_held;
            phase_in = fin_phase;
            two_in = (res_num == 2'd2);
            emit_in = 1'b0;
            state_in = (res_num == 2'd0) ? ST_IDLE : ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_fire) begin
               if (emit_ff || !two_ff) state_in = ST_IDLE;
               else emit_in = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (key_wr) begin
         state_in = ST_KEYX;
         kx_cnt_in = '0;
      end
   end

   // Cipher datapath.
   always_comb begin
      aes_state_in = aes_state_ff;
      aes_src_in = aes_src_ff;
      r1_in = r1_ff;
      x_in = x_ff;
      c_in = c_ff;
      last_in = last_ff;
      kind_in = kind_ff;
      res_in = res_ff;
      if (state_ff == ST_IDLE && req_fire) begin
         x_in = x_new;
         c_in = c_sat;
         last_in = req_stream.in_last;
         kind_in = kind_new;
         aes_src_in = src1;
      end
      if (state_ff == ST_AES2 && st_ff == 4'd0) begin
         r1_in = aes_state_ff;
         if (kind_ff == K_E_STREAM) aes_src_in = x_ff ^ aes_state_ff;
         else aes_src_in = (x_ff & m) | ((aes_state_ff ^ x_ff) & ~m);
      end
      if ((state_ff == ST_AES1 || state_ff == ST_AES2) && st_ff != 4'd0) begin
         aes_state_in = (st_ff == 4'd1) ? (aes_src_ff ^ round_key) : round_out;
      end
      if (state_ff == ST_FIN) begin
         res_in[0] = res0;
         res_in[1] = res1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) key_ff[i] <= '0;
         iv_hi_ff <= '0;
         iv_lo_ff <= '0;
         dir_ff <= 1'b0;
         state_ff <= ST_IDLE;
         st_ff <= '0;
         kx_cnt_ff <= '0;
         emit_ff <= 1'b0;
         two_ff <= 1'b0;
         phase_ff <= PH_IDLE;
         chain_ff <= '0;
         held_ff <= '0;
      end else begin
         key_ff <= key_in;
         iv_hi_ff <= iv_hi_in;
         iv_lo_ff <= iv_lo_in;
         dir_ff <= dir_in;
         state_ff <= state_in;
         st_ff <= st_in;
         kx_cnt_ff <= kx_cnt_in;
         emit_ff <= emit_in;
         two_ff <= two_in;
         phase_ff <= phase_in;
         chain_ff <= chain_in;
         held_ff <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
      rcon_ff <= rcon_in;
      aes_state_ff <= aes_state_in;
      aes_src_ff <= aes_src_in;
      r1_ff <= r1_in;
      x_ff <= x_in;
      c_ff <= c_in;
      last_ff <= last_in;
      kind_ff <= kind_in;
      res_ff <= res_in;
   end

   assign rsp_stream.valid = (state_ff == ST_EMIT);
   assign rsp_stream.out_hi = res_ff[emit_ff].data[127:64];
   assign rsp_stream.out_lo = res_ff[emit_ff].data[63:0];
   assign rsp_stream.out_count = res_ff[emit_ff].count;
   assign rsp_stream.out_last = res_ff[emit_ff].last;
   assign rsp_stream.out_error = res_ff[emit_ff].err;

   a_one_request_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_stream.ready)
      else $error("request accepted while a previous one is still in work");

   a_only_final_is_short: assert property (@(posedge clock) disable iff (reset)
      rsp_stream.valid && !rsp_stream.out_last |-> rsp_stream.out_count == BLOCK_BYTES)
      else $error("short response that is not the final one");

   a_error_is_empty_final: assert property (@(posedge clock) disable iff (reset)
      rsp_stream.valid && rsp_stream.out_error |->
         rsp_stream.out_last && rsp_stream.out_count == '0)
      else $error("error response that is not an empty final response");

   a_key_expansion_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_KEYX |-> kx_cnt_ff <= KX_LAST)
      else $error("key expansion ran past the last round key entry");

endmodule

`default_nettype wire
